@@ rtl/btpt_pkg.sv @@
`default_nettype none

package btpt_pkg;

    // Image geometry and set point
    localparam logic [9:0]  CENTER_COL     = 10'd320;
    localparam logic [9:0]  CENTER_ROW     = 10'd240;
    localparam logic [19:0] TARGET_AREA    = 20'd122880;
    localparam logic [7:0]  LATERAL_OFFSET = 8'd35;

    localparam int GAIN_W = 48;

    // Error scaling: round(|num| * 2^13 / den) as (y * RECIP) >> RECIP_SHIFT.
    // den / 2^13 is 15 for the area, 5/128 for the column and 15/512 for the row.
    localparam int DIV_MAG_W   = 21;
    localparam int DIV_Q_W     = 17;
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 25;

    // ceil(2^25 / 15) and ceil(2^25 / 5), exact over the dividend range used
    localparam logic [RECIP_W-1:0]   RECIP_15 = 23'd2236963;
    localparam logic [RECIP_W-1:0]   RECIP_5  = 23'd6710887;
    // (d - 1) / 2 for nearest rounding; an odd divisor never gives a tie
    localparam logic [DIV_MAG_W-1:0] ROUND_15 = 21'd7;
    localparam logic [DIV_MAG_W-1:0] ROUND_5  = 21'd2;

    // Register indexes, also used as axis codes
    localparam logic [1:0] REG_GAINS_FORWARD  = 2'd0;
    localparam logic [1:0] REG_GAINS_LATERAL  = 2'd1;
    localparam logic [1:0] REG_GAINS_VERTICAL = 2'd2;

    localparam logic [1:0] AXIS_FORWARD  = 2'd0;
    localparam logic [1:0] AXIS_LATERAL  = 2'd1;
    localparam logic [1:0] AXIS_VERTICAL = 2'd2;

    typedef struct packed {
        logic       is_person;
        logic [9:0] box_left;
        logic [9:0] box_right;
        logic [9:0] box_top;
        logic [9:0] box_bottom;
        logic       frame_end;
    } box_item_t;

    typedef struct packed {
        logic signed [15:0] vel_forward;
        logic signed [15:0] vel_lateral;
        logic signed [15:0] vel_vertical;
    } vel_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AREA,
        ST_SELECT,
        ST_FRAME,
        ST_DIV_LOAD,
        ST_DIV_WAIT,
        ST_ERROR,
        ST_MUL_P,
        ST_MUL_D,
        ST_MUL_I,
        ST_ACC,
        ST_PID_OUT,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

@@ rtl/btpt_div.sv @@
`default_nettype none

// Error scaling by reciprocal multiplication: quotient is the magnitude times 2^13
// over the axis's fixed denominator, rounded to nearest; done follows start via load_reg, done_reg
module btpt_div
    import btpt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [1:0]           axis,
    input  wire logic [DIV_MAG_W-1:0] magnitude,
    output logic                      done,
    output logic [DIV_Q_W-1:0]        quotient
);

    logic                         load_reg;
    logic                         done_reg;
    logic [DIV_MAG_W-1:0]         dvd_reg;
    logic [RECIP_W-1:0]           recip_reg;
    logic [DIV_MAG_W+RECIP_W-1:0] prod_reg;

    logic [DIV_MAG_W-1:0]         dvd_next;
    logic [RECIP_W-1:0]           recip_next;

    always_comb
    begin
        case (axis)
            AXIS_FORWARD:
            begin
                dvd_next   = magnitude + ROUND_15;
                recip_next = RECIP_15;
            end
            AXIS_LATERAL:
            begin
                dvd_next   = {magnitude[DIV_MAG_W-8:0], 7'b0} + ROUND_5;
                recip_next = RECIP_5;
            end
            default:
            begin
                dvd_next   = {magnitude[DIV_MAG_W-10:0], 9'b0} + ROUND_15;
                recip_next = RECIP_15;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            load_reg <= start;
            done_reg <= load_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg   <= dvd_next;
            recip_reg <= recip_next;
        end
        if (load_reg)
            prod_reg <= dvd_reg * recip_reg;
    end

    assign done     = done_reg;
    assign quotient = prod_reg[RECIP_SHIFT+DIV_Q_W-1:RECIP_SHIFT];

endmodule

`default_nettype wire

@@ rtl/bbox_target_pid_tracker_unit.sv @@
// Person tracker with three PID loops.
// in_valid/in_ready carry one detection box per item; out_valid/out_ready carry
// one item of three Q4.11 velocities. cfg_write with cfg_index/cfg_data loads
// the packed kp/kd/ki gains of one axis. The sequencer takes no new box until
// it is back in idle. A box with frame_end and a valid target runs all three
// axes: each forms its error by a reciprocal multiply, then makes three passes
// through the one shared 16x24 multiplier; the result register is loaded after
// the last axis. A frame end without a target returns to idle with no result.
// The output register parts the two sides: the next box is taken while a
// result waits. If the receiver still holds the earlier result when the next
// one is ready, the sequencer waits in its final step and in_ready stays low.
// Reset clears gains, tracking state and PID history, and drops any pending
// result.
`default_nettype none

module bbox_target_pid_tracker_unit
    import btpt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire box_item_t         in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output vel_item_t              out_data,
    input  wire logic              cfg_write,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [GAIN_W-1:0] cfg_data
);

    state_t state_reg;
    state_t state_next;

    logic [GAIN_W-1:0] gains_reg [3];

    logic               tracking_active_reg;
    logic [9:0]         last_center_col_reg;
    logic [9:0]         best_distance_reg;
    logic               target_found_reg;
    logic               person_seen_reg;
    logic signed [20:0] target_area_reg;
    logic [9:0]         target_center_col_reg;
    logic [9:0]         target_center_row_reg;
    logic signed [23:0] integral_reg [3];
    logic signed [15:0] prev_error_reg [3];
    logic signed [15:0] vel_reg [3];
    logic [1:0]         axis_reg;

    box_item_t          box_reg;
    logic signed [39:0] prod_reg;
    logic signed [41:0] acc_reg;
    logic signed [15:0] error_reg;
    logic signed [23:0] integ_reg;
    logic signed [16:0] deriv_reg;
    logic               neg_reg;

    logic      out_valid_reg;
    vel_item_t out_data_reg;

    // box geometry
    logic signed [11:0] dcol, drow, half_col, half_row;
    logic [11:0]        col_sum, row_sum;
    logic [9:0]         center_col, center_row, ref_col, col_dist;
    logic [10:0]        cdiff, cdiff_abs;

    // error and PID datapath
    logic signed [21:0]   num;
    logic [DIV_MAG_W-1:0] num_abs;
    logic                 div_start;
    logic                 div_done;
    logic [DIV_Q_W-1:0]   div_quo;
    logic [DIV_Q_W-1:0]   neg_q;
    logic signed [15:0]   error_sat;
    logic [24:0]          integ_sum;
    logic signed [23:0]   integ_sat;
    logic [GAIN_W-1:0]    gain;
    logic signed [15:0]   mul_a;
    logic signed [23:0]   mul_b;
    logic [41:0]          rounded;
    logic [31:0]          scaled;
    logic signed [15:0]   vel_sat;
    logic                 emit_fire;

    always_comb
    begin
        dcol     = $signed({2'b00, box_reg.box_right}) - $signed({2'b00, box_reg.box_left});
        drow     = $signed({2'b00, box_reg.box_bottom}) - $signed({2'b00, box_reg.box_top});
        // halve toward zero
        half_col = (dcol + $signed({11'b0, dcol[11]})) >>> 1;
        half_row = (drow + $signed({11'b0, drow[11]})) >>> 1;
        col_sum  = {2'b00, box_reg.box_left} + half_col;
        row_sum  = {2'b00, box_reg.box_top} + half_row;
        center_col = col_sum[9:0];
        center_row = row_sum[9:0];
        ref_col    = tracking_active_reg ? last_center_col_reg : CENTER_COL;
        cdiff      = {1'b0, ref_col} - {1'b0, center_col};
        cdiff_abs  = cdiff[10] ? (11'd0 - cdiff) : cdiff;
        col_dist   = cdiff_abs[9:0];
    end

    always_comb
    begin
        case (axis_reg)
            AXIS_FORWARD:
                num = $signed({2'b00, TARGET_AREA})
                    - $signed({target_area_reg[20], target_area_reg});
            AXIS_LATERAL:
                num = $signed({12'b0, CENTER_COL}) - $signed({12'b0, target_center_col_reg})
                    + $signed({14'b0, LATERAL_OFFSET});
            default:
                num = $signed({12'b0, CENTER_ROW}) - $signed({12'b0, target_center_row_reg});
        endcase
        num_abs = num[21] ? DIV_MAG_W'(22'd0 - num) : num[DIV_MAG_W-1:0];
    end

    btpt_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .axis      (axis_reg),
        .magnitude (num_abs),
        .done      (div_done),
        .quotient  (div_quo)
    );

    always_comb
    begin
        neg_q = DIV_Q_W'(0) - div_quo;
        if (!neg_reg)
            error_sat = (div_quo > DIV_Q_W'(32767)) ? 16'sh7FFF : $signed(div_quo[15:0]);
        else
            error_sat = (div_quo > DIV_Q_W'(32768)) ? 16'sh8000 : $signed(neg_q[15:0]);

        integ_sum = {integral_reg[axis_reg][23], integral_reg[axis_reg]}
                  + {{9{error_reg[15]}}, error_reg};
        if (integ_sum[24] != integ_sum[23])
            integ_sat = integ_sum[24] ? 24'sh800000 : 24'sh7FFFFF;
        else
            integ_sat = $signed(integ_sum[23:0]);

        rounded = acc_reg + 42'sd512;
        scaled  = rounded[41:10];
        if (scaled[31:15] != {17{1'b0}} && scaled[31:15] != {17{1'b1}})
            vel_sat = scaled[31] ? 16'sh8000 : 16'sh7FFF;
        else
            vel_sat = $signed(scaled[15:0]);
    end

    assign gain = gains_reg[axis_reg];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_AREA;
            ST_AREA:
                state_next = ST_SELECT;
            ST_SELECT:
                state_next = box_reg.frame_end ? ST_FRAME : ST_IDLE;
            ST_FRAME:
                if (target_found_reg && target_center_col_reg != 10'd0
                    && target_center_row_reg != 10'd0)
                    state_next = ST_DIV_LOAD;
                else
                    state_next = ST_IDLE;
            ST_DIV_LOAD:
                state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (div_done)
                    state_next = ST_ERROR;
            ST_ERROR:
                state_next = ST_MUL_P;
            ST_MUL_P:
                state_next = ST_MUL_D;
            ST_MUL_D:
                state_next = ST_MUL_I;
            ST_MUL_I:
                state_next = ST_ACC;
            ST_ACC:
                state_next = ST_PID_OUT;
            ST_PID_OUT:
                state_next = (axis_reg == AXIS_VERTICAL) ? ST_EMIT : ST_DIV_LOAD;
            ST_EMIT:
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control outputs and multiplier operand select
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_DIV_LOAD);
        emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
        case (state_reg)
            ST_AREA:
            begin
                mul_a = {{4{dcol[11]}}, dcol};
                mul_b = {{12{drow[11]}}, drow};
            end
            ST_MUL_P:
            begin
                mul_a = $signed(gain[15:0]);
                mul_b = {{8{error_reg[15]}}, error_reg};
            end
            ST_MUL_D:
            begin
                mul_a = $signed(gain[31:16]);
                mul_b = {{7{deriv_reg[16]}}, deriv_reg};
            end
            ST_MUL_I:
            begin
                mul_a = $signed(gain[47:32]);
                mul_b = integ_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                gains_reg[k]      <= '0;
                integral_reg[k]   <= '0;
                prev_error_reg[k] <= '0;
            end
            tracking_active_reg   <= 1'b0;
            last_center_col_reg   <= '0;
            best_distance_reg     <= CENTER_COL;
            target_found_reg      <= 1'b0;
            person_seen_reg       <= 1'b0;
            target_area_reg       <= '0;
            target_center_col_reg <= '0;
            target_center_row_reg <= '0;
            axis_reg              <= AXIS_FORWARD;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_GAINS_FORWARD:  gains_reg[0] <= cfg_data;
                    REG_GAINS_LATERAL:  gains_reg[1] <= cfg_data;
                    REG_GAINS_VERTICAL: gains_reg[2] <= cfg_data;
                    default:            ;
                endcase
            end

            if (state_reg == ST_SELECT && box_reg.is_person)
            begin
                person_seen_reg <= 1'b1;
                if (col_dist < best_distance_reg)
                begin
                    best_distance_reg     <= col_dist;
                    target_found_reg      <= 1'b1;
                    target_area_reg       <= prod_reg[20:0];
                    target_center_col_reg <= center_col;
                    target_center_row_reg <= center_row;
                end
            end

            if (state_reg == ST_FRAME)
            begin
                if (target_found_reg)
                    last_center_col_reg <= target_center_col_reg;
                tracking_active_reg <= tracking_active_reg | person_seen_reg;
                best_distance_reg   <= CENTER_COL;
                target_found_reg    <= 1'b0;
                person_seen_reg     <= 1'b0;
                axis_reg            <= AXIS_FORWARD;
            end

            if (state_reg == ST_PID_OUT)
            begin
                integral_reg[axis_reg]   <= integ_reg;
                prev_error_reg[axis_reg] <= error_reg;
                if (axis_reg != AXIS_VERTICAL)
                    axis_reg <= axis_reg + 2'd1;
            end

            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (in_valid && in_ready)
            box_reg <= in_data;
        if (state_reg == ST_DIV_LOAD)
            neg_reg <= num[21];
        if (state_reg == ST_ERROR)
            error_reg <= error_sat;
        if (state_reg == ST_MUL_P)
        begin
            integ_reg <= integ_sat;
            deriv_reg <= {error_reg[15], error_reg}
                       - {prev_error_reg[axis_reg][15], prev_error_reg[axis_reg]};
        end
        case (state_reg)
            ST_MUL_D: acc_reg <= {{2{prod_reg[39]}}, prod_reg};
            ST_MUL_I: acc_reg <= acc_reg + {{2{prod_reg[39]}}, prod_reg};
            ST_ACC:   acc_reg <= acc_reg + {{2{prod_reg[39]}}, prod_reg};
            default:  ;
        endcase
        if (state_reg == ST_PID_OUT)
            vel_reg[axis_reg] <= vel_sat;
        if (emit_fire)
        begin
            out_data_reg.vel_forward  <= vel_reg[0];
            out_data_reg.vel_lateral  <= vel_reg[1];
            out_data_reg.vel_vertical <= vel_reg[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ bench/pid_velocity_checker.sv @@
`default_nettype none

module pid_velocity_checker
    import btpt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire box_item_t         in_data,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire vel_item_t         out_data,
    input  wire logic              cfg_write,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [GAIN_W-1:0] cfg_data,
    output int                     fail_count,
    output int                     pending,
    output int                     results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [GAIN_W-1:0] axis_gains [3];
    bit                tracking;
    int                last_col;
    int                best_dist;
    bit                found;
    bit                seen;
    int                tgt_area;
    int                tgt_col;
    int                tgt_row;
    longint            integ [3];
    longint            prev_err [3];

    vel_item_t         expected_vel [$];
    vel_item_t         want;
    int                fails;
    int                checked;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // integer division truncates toward zero, so the centre stays between the edges
    function automatic int halfway(int a, int b);
        return a + (b - a) / 2;
    endfunction

    // num/den in Q2.13, nearest with ties away from zero
    function automatic longint to_q13(longint num, longint den);
        longint n;
        longint m;
        longint q;
        n = num * 8192;
        m = n < 0 ? -n : n;
        q = (2 * m + den) / (2 * den);
        return clip(n < 0 ? -q : q, -32768, 32767);
    endfunction

    function automatic logic [15:0] pid_axis(int axis, longint e);
        logic [GAIN_W-1:0] g;
        longint acc;
        longint der;
        longint kp;
        longint kd;
        longint ki;
        longint s;
        g   = axis_gains[axis];
        acc = clip(integ[axis] + e, -8388608, 8388607);
        der = e - prev_err[axis];
        kp  = $signed(g[15:0]);
        kd  = $signed(g[31:16]);
        ki  = $signed(g[47:32]);
        s   = kp * e + kd * der + ki * acc;
        integ[axis]    = acc;
        prev_err[axis] = e;
        // Q.21 sum, round half up to Q4.11
        return 16'(clip((s + 512) >>> 10, -32768, 32767));
    endfunction

    task automatic track_box(input box_item_t b);
        int        l;
        int        r;
        int        t;
        int        bt;
        int        c;
        int        aim;
        int        col_dist;
        longint    ex;
        longint    ey;
        longint    ez;
        vel_item_t v;
        l  = b.box_left;
        r  = b.box_right;
        t  = b.box_top;
        bt = b.box_bottom;
        if (b.is_person)
        begin
            c        = halfway(l, r);
            aim      = tracking ? last_col : int'(CENTER_COL);
            col_dist = aim - c;
            if (col_dist < 0)
                col_dist = -col_dist;
            seen = 1'b1;
            // strict compare: a tie keeps the earlier box
            if (col_dist < best_dist)
            begin
                best_dist = col_dist;
                found     = 1'b1;
                tgt_area  = (r - l) * (bt - t);
                tgt_col   = c;
                tgt_row   = halfway(t, bt);
            end
        end
        if (b.frame_end)
        begin
            if (found)
            begin
                last_col = tgt_col;
                if (tgt_col != 0 && tgt_row != 0)
                begin
                    ex = to_q13(longint'(TARGET_AREA) - tgt_area, longint'(TARGET_AREA));
                    ey = to_q13(longint'(CENTER_COL) - tgt_col + longint'(LATERAL_OFFSET),
                                longint'(CENTER_COL));
                    ez = to_q13(longint'(CENTER_ROW) - tgt_row, longint'(CENTER_ROW));
                    v.vel_forward  = pid_axis(AXIS_FORWARD, ex);
                    v.vel_lateral  = pid_axis(AXIS_LATERAL, ey);
                    v.vel_vertical = pid_axis(AXIS_VERTICAL, ez);
                    expected_vel.push_back(v);
                end
            end
            if (seen)
                tracking = 1'b1;
            best_dist = int'(CENTER_COL);
            found     = 1'b0;
            seen      = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        fails++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                axis_gains[k] = '0;
                integ[k]      = 0;
                prev_err[k]   = 0;
            end
            tracking  = 1'b0;
            last_col  = 0;
            best_dist = int'(CENTER_COL);
            found     = 1'b0;
            seen      = 1'b0;
            tgt_area  = 0;
            tgt_col   = 0;
            tgt_row   = 0;
            expected_vel.delete();
            fails   = 0;
            checked = 0;
            fail_count   <= 0;
            pending      <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (cfg_write && cfg_index <= REG_GAINS_VERTICAL)
                axis_gains[cfg_index] = cfg_data;
            // output side first, so a result cannot match an item taken in the same cycle
            if (out_valid && out_ready)
            begin
                if (expected_vel.size() == 0)
                    report_mismatch($sformatf("velocity item %0h with none expected", out_data));
                else
                begin
                    want = expected_vel.pop_front();
                    checked++;
                    if (out_data.vel_forward !== want.vel_forward)
                        report_mismatch($sformatf("item %0d vel_forward got %0d want %0d",
                            checked, out_data.vel_forward, want.vel_forward));
                    if (out_data.vel_lateral !== want.vel_lateral)
                        report_mismatch($sformatf("item %0d vel_lateral got %0d want %0d",
                            checked, out_data.vel_lateral, want.vel_lateral));
                    if (out_data.vel_vertical !== want.vel_vertical)
                        report_mismatch($sformatf("item %0d vel_vertical got %0d want %0d",
                            checked, out_data.vel_vertical, want.vel_vertical));
                end
            end
            if (in_valid && in_ready)
                track_box(in_data);
            fail_count   <= fails;
            pending      <= expected_vel.size();
            results_seen <= checked;
        end
    end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import btpt_pkg::*;

    localparam int IDLE_LIMIT     = 2000;
    localparam int SETTLE_CYCLES  = 150;
    localparam int SAT_FRAMES     = 270;
    localparam int FRAMES_PER_SET = 30;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    box_item_t         in_data;
    logic              out_valid;
    logic              out_ready;
    vel_item_t         out_data;
    logic              cfg_write;
    logic [1:0]        cfg_index;
    logic [GAIN_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int results_seen;
    int idle_cycles;
    int stall_left;
    bit no_idle;
    int boxes_sent;
    int frames_sent;
    int settings_used;

    bbox_target_pid_tracker_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pid_velocity_checker vel_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic box_item_t box_of(bit p, int l, int r, int t, int bt, bit last);
        box_item_t b;
        b.is_person  = p;
        b.box_left   = 10'(l);
        b.box_right  = 10'(r);
        b.box_top    = 10'(t);
        b.box_bottom = 10'(bt);
        b.frame_end  = last;
        return b;
    endfunction

    function automatic logic [GAIN_W-1:0] pack_gains(logic [15:0] kp, logic [15:0] kd,
                                                     logic [15:0] ki);
        return {ki, kd, kp};
    endfunction

    function automatic logic [15:0] small_gain();
        return 16'($urandom_range(0, 1024) - 512);
    endfunction

    task automatic send_box(input box_item_t b, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (!in_ready);
        boxes_sent++;
        if (b.frame_end)
            frames_sent++;
    endtask

    // the sender holds off until every expected item has arrived
    task automatic drain(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [GAIN_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_gains(input logic [GAIN_W-1:0] fwd, input logic [GAIN_W-1:0] lat,
                              input logic [GAIN_W-1:0] ver);
        set_reg(REG_GAINS_FORWARD, fwd);
        set_reg(REG_GAINS_LATERAL, lat);
        set_reg(REG_GAINS_VERTICAL, ver);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (no_idle || $urandom_range(0, 3) != 0)
            out_ready <= 1'b1;
        else
        begin
            out_ready  <= 1'b0;
            stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles, %0d items outstanding",
                         IDLE_LIMIT, pending);
                $display("*** FAILED ***");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
        else
            idle_cycles <= 0;
    end

    initial
    begin
        int          n;
        int          l;
        int          r;
        int          t;
        int          bt;
        int          tmp;
        logic [63:0] raw;
        box_item_t   b;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= REG_GAINS_FORWARD;
        cfg_data  <= '0;
        no_idle   <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_gains(pack_gains(16'h0100, 16'h0040, 16'h0008),
                   pack_gains(16'h0200, 16'hFF80, 16'h0004),
                   pack_gains(16'h0180, 16'h0020, 16'hFFF0));

        // directed frames
        send_box(box_of(1'b0, 100, 200, 100, 200, 1'b1), pick_gap());    // no person at all
        send_box(box_of(1'b1, 128, 512, 80, 400, 1'b1), pick_gap());     // centred, with exactly the target area
        send_box(box_of(1'b1, 1000, 1023, 0, 50, 1'b0), pick_gap());     // too far to count
        send_box(box_of(1'b0, 0, 0, 0, 0, 1'b1), pick_gap());            // frame with no target
        send_box(box_of(1'b1, 290, 310, 100, 300, 1'b0), pick_gap());    // tie: first wins
        send_box(box_of(1'b1, 330, 350, 100, 300, 1'b0), pick_gap());
        send_box(box_of(1'b1, 200, 260, 0, 40, 1'b1), pick_gap());
        send_box(box_of(1'b1, 500, 100, 0, 1023, 1'b1), pick_gap());     // inverted columns
        send_box(box_of(1'b1, 0, 1, 100, 200, 1'b1), pick_gap());        // centre column zero
        send_box(box_of(1'b1, 0, 20, 0, 1, 1'b1), pick_gap());           // centre row zero
        send_box(box_of(1'b1, 0, 640, 0, 1023, 1'b1), pick_gap());       // huge area
        send_box(box_of(1'b1, 1023, 1023, 1023, 1023, 1'b1), pick_gap());
        send_box(box_of(1'b1, 300, 340, 1023, 900, 1'b0), pick_gap());   // inverted rows
        send_box(box_of(1'b0, 1023, 1023, 1023, 1023, 1'b1), pick_gap()); // end on a non-person
        send_box(box_of(1'b1, 321, 1023, 0, 1023, 1'b0), pick_gap());
        send_box(box_of(1'b1, 0, 1023, 0, 0, 1'b1), pick_gap());
        send_box(box_of(1'b1, 800, 1022, 600, 1000, 1'b1), pick_gap());

        // large inverted boxes push the forward error to its ceiling until the integral clips
        drain(SETTLE_CYCLES);
        load_gains(pack_gains(16'h0010, 16'h0020, 16'h0001),
                   pack_gains(16'h0100, 16'h0100, 16'h0001),
                   pack_gains(16'h0100, 16'h0000, 16'h0001));
        for (int f = 0; f < SAT_FRAMES; f++)
            send_box(box_of(1'b1, $urandom_range(0, 50), $urandom_range(700, 760),
                            $urandom_range(800, 1023), $urandom_range(0, 150), 1'b1),
                     pick_gap());

        for (int s = 0; s < 5; s++)
        begin
            drain(SETTLE_CYCLES);
            no_idle <= (s == 3);
            case (s)
                0: load_gains(pack_gains(16'h7FFF, 16'h7FFF, 16'h7FFF),
                              pack_gains(16'h7FFF, 16'h7FFF, 16'h7FFF),
                              pack_gains(16'h7FFF, 16'h7FFF, 16'h7FFF));
                1: load_gains(pack_gains(16'h8000, 16'h8000, 16'h8000),
                              pack_gains(16'h8000, 16'h8000, 16'h8000),
                              pack_gains(16'h8000, 16'h8000, 16'h8000));
                2: load_gains(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                              48'({$urandom(), $urandom()}));
                3: load_gains(pack_gains(small_gain(), small_gain(), small_gain()),
                              pack_gains(small_gain(), small_gain(), small_gain()),
                              pack_gains(small_gain(), small_gain(), small_gain()));
                default: load_gains('0, '0, '0);
            endcase
            for (int f = 0; f < FRAMES_PER_SET; f++)
            begin
                if (f == FRAMES_PER_SET / 2)
                    drain(0);
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        // noise: any bit pattern, frame end included
                        raw = {$urandom(), $urandom()};
                        b   = raw[$bits(box_item_t)-1:0];
                    end
                    else
                    begin
                        l  = $urandom_range(0, 700);
                        r  = l + $urandom_range(0, 323);
                        t  = $urandom_range(0, 700);
                        bt = t + $urandom_range(0, 323);
                        if ($urandom_range(0, 9) == 0)
                        begin
                            tmp = l;
                            l   = r;
                            r   = tmp;
                        end
                        if ($urandom_range(0, 9) == 0)
                        begin
                            tmp = t;
                            t   = bt;
                            bt  = tmp;
                        end
                        b = box_of($urandom_range(0, 19) != 0, l, r, t, bt, i == n - 1);
                    end
                    send_box(b, pick_gap());
                end
            end
        end
        no_idle <= 1'b0;

        drain(SETTLE_CYCLES);
        $display("Sent %0d boxes in %0d frames under %0d gain settings; %0d velocity items checked.",
                 boxes_sent, frames_sent, settings_used, results_seen);
        $display("Covered tie breaks, inverted boxes, zero centres, integral and output clipping.");
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
